### rtl/bfrk_pkg.sv
package bfrk_pkg;

    // Key and hash geometry
    localparam int KEY_W    = 32;
    localparam int NUM_HASH = 3;
    localparam int ROT_A    = 8;
    localparam int ROT_B    = 16;
    localparam int ROT_C    = 24;

    // Opcodes carried by each input beat
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CHECK  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RUN,
        ST_CLEAR,
        ST_FIN
    } state_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_stat_t;

endpackage

### rtl/bfrk_ram.sv
module bfrk_ram
    #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bfrk_front.sv
module bfrk_front
    import bfrk_pkg::*;
    #(
    parameter int FILTER_BITS = 16
    )
    (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [KEY_W-1:0]                  key,
    input  back_stat_t                        stat,
    output logic                              head_valid,
    output op_t                               head_op,
    output logic [NUM_HASH-1:0][FILTER_BITS-1:0] head_idx
    );

    localparam int QDEPTH = 2;

    logic [1:0]                                  count_reg, count_next;
    logic                                        wr_ptr_reg, wr_ptr_next;
    logic                                        rd_ptr_reg, rd_ptr_next;
    op_t                                         q_op_reg  [QDEPTH];
    logic [NUM_HASH-1:0][FILTER_BITS-1:0]        q_idx_reg [QDEPTH];
    logic [NUM_HASH-1:0][FILTER_BITS-1:0]        idx;
    logic                                        push;

    // Fold a rotated key down to a bit index
    function automatic logic [FILTER_BITS-1:0] fold(input logic [KEY_W-1:0] h);
        logic [KEY_W-1:0] hi;
        hi = h >> FILTER_BITS;
        return hi[FILTER_BITS-1:0] ^ h[FILTER_BITS-1:0];
    endfunction

    // Hash the key with three rotations
    always_comb
    begin
        idx[0] = fold((key >> ROT_A) | (key << (KEY_W - ROT_A)));
        idx[1] = fold((key >> ROT_B) | (key << (KEY_W - ROT_B)));
        idx[2] = fold((key >> ROT_C) | (key << (KEY_W - ROT_C)));
    end

    assign in_ready   = (count_reg != 2'd2) && !stat.init_busy;
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_op    = q_op_reg[rd_ptr_reg];
    assign head_idx   = q_idx_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = stat.pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, stat.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Hold classified beats in the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]  <= op_t'(opcode);
            q_idx_reg[wr_ptr_reg] <= idx;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill level out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> head_valid)
        else $error("pop from empty queue");

    a_no_push_init: assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> !push)
        else $error("beat taken during clearing pass");

endmodule

### rtl/bfrk_back.sv
module bfrk_back
    import bfrk_pkg::*;
    #(
    parameter int FILTER_BITS = 16
    )
    (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_valid,
    input  op_t                                  head_op,
    input  logic [NUM_HASH-1:0][FILTER_BITS-1:0] head_idx,
    output back_stat_t                           stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           done_kind,
    output logic                                 member
    );

    localparam int DEPTH = 1 << FILTER_BITS;

    state_t                 state_reg, state_next;
    logic [FILTER_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]             step_reg, step_next;
    logic                   acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             done_kind_reg;
    logic                   member_reg;
    logic                   ram_we;
    logic [FILTER_BITS-1:0] ram_addr;
    logic                   ram_wdata;
    logic                   ram_rdata;
    logic                   load;
    logic                   pop;

    bfrk_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequence the bit accesses of the head item and the clearing sweeps
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        ram_we     = 1'b0;
        ram_wdata  = 1'b0;
        ram_addr   = head_idx[2];
        load       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head_op)
                        OP_INSERT:
                        begin
                            ram_addr   = head_idx[0];
                            ram_we     = 1'b1;
                            ram_wdata  = 1'b1;
                            step_next  = 2'd1;
                            state_next = ST_RUN;
                        end
                        OP_CHECK:
                        begin
                            ram_addr   = head_idx[0];
                            step_next  = 2'd1;
                            state_next = ST_RUN;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                ram_addr  = (step_reg == 2'd1) ? head_idx[1] : head_idx[2];
                ram_we    = (head_op == OP_INSERT);
                ram_wdata = 1'b1;
                acc_next  = (step_reg == 2'd1) ? ram_rdata : (acc_reg & ram_rdata);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Address holds at the third index, so read data stays put
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    pop        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drop the output beat once taken, refill on completion
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load)
        begin
            done_kind_reg <= head_op;
            member_reg    <= (head_op == OP_CHECK) && acc_reg && ram_rdata;
        end
    end

    assign stat.pop       = pop;
    assign stat.init_busy = (state_reg == ST_INIT);
    assign out_valid      = out_valid_reg;
    assign done_kind      = done_kind_reg;
    assign member         = member_reg;

    a_run_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN || state_reg == ST_FIN || state_reg == ST_CLEAR)
        |-> head_valid)
        else $error("sequencer busy without a queued item");

    a_pop_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_FIN))
        else $error("item retired outside completion state");

    a_sweep_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT || state_reg == ST_CLEAR) |-> (ram_we && !ram_wdata))
        else $error("clearing sweep not writing zero");

endmodule

### rtl/bloom_filter_rotated_key.sv
// Bloom filter over 2^FILTER_BITS bits held in a single-port one-bit-wide RAM.
// Each beat carries an opcode (insert, check, clear) and a 32-bit key; the key
// is rotated right by 8, 16 and 24 and each rotation is xor-folded into a bit
// index. A two-entry queue decouples the input side from the RAM sequencer,
// and one output register holds the result beat. Insert and check each make
// three RAM accesses on the single port and then pass through a completion
// state, an unused opcode goes straight to completion, and clear sweeps every
// bit, writing one bit per cycle, before completing. After reset the same
// sweep runs over every bit with in_ready held low.
module bloom_filter_rotated_key
    import bfrk_pkg::*;
    #(
    parameter int FILTER_BITS = 16
    )
    (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [KEY_W-1:0] key,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       done_kind,
    output logic             member
    );

    back_stat_t                           stat;
    logic                                 head_valid;
    op_t                                  head_op;
    logic [NUM_HASH-1:0][FILTER_BITS-1:0] head_idx;

    bfrk_front #(
        .FILTER_BITS (FILTER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .stat       (stat),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_idx   (head_idx)
    );

    bfrk_back #(
        .FILTER_BITS (FILTER_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_idx   (head_idx),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .done_kind  (done_kind),
        .member     (member)
    );

endmodule
